>>> rtl/core/skt_pkg.sv
// Package for the sorted key table: opcodes, status codes, field widths and
// the control and flag structs passed between the top level and its cells.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

  // Fixed widths of the request and result fields.
  localparam int OP_W      = 2;
  localparam int KEY_PORT_W = 16;
  localparam int PAY_W     = 16;
  localparam int POS_W     = 4;
  localparam int USED_W    = 5;

  // Default sizing of the table.
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

  // Per-cell control computed at the top level.
  typedef struct packed {
    logic ins;       // accepted insert with room left
    logic rem;       // accepted remove
    logic found;     // the remove key is held somewhere
    logic occupied;  // cell index is below the fill count
    logic at_tail;   // cell index equals the fill count
    logic left_gt;   // left neighbor holds a key above the request key
  } cell_ctl_t;

  // Compare results each cell reports back.
  typedef struct packed {
    logic gt;     // occupied and key above request key
    logic ge;     // occupied and key at or above request key
    logic match;  // occupied and key equal to request key
  } cell_flag_t;

endpackage

>>> rtl/core/skt_cell.sv
// One cell of the sorted key table: holds one key and payload, compares
// against the request key and shifts right, left or loads. Uses skt_pkg.
`timescale 1ns / 1ps

module skt_cell
  import skt_pkg::*;
#(
  parameter int KEY_W = DEF_KEY_BITS
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] cmd_key,
  input  logic [PAY_W-1:0] cmd_payload,
  input  logic [KEY_W-1:0] left_key,
  input  logic [PAY_W-1:0] left_payload,
  input  logic [KEY_W-1:0] right_key,
  input  logic [PAY_W-1:0] right_payload,
  output cell_flag_t       flags,
  output logic [KEY_W-1:0] key,
  output logic [PAY_W-1:0] payload
);

  logic [KEY_W-1:0] key_next;
  logic [PAY_W-1:0] payload_next;

  // Compare the held key with the request key.
  always_comb begin
    flags.gt    = ctl.occupied && (key > cmd_key);
    flags.ge    = ctl.occupied && (key >= cmd_key);
    flags.match = ctl.occupied && (key == cmd_key);
  end

  // Insert shifts larger keys right and drops the new entry into the gap;
  // remove pulls every entry from the first match onward one place left.
  always_comb begin
    key_next     = key;
    payload_next = payload;
    if (ctl.ins) begin
      if (ctl.left_gt) begin
        key_next     = left_key;
        payload_next = left_payload;
      end else if (flags.gt || ctl.at_tail) begin
        key_next     = cmd_key;
        payload_next = cmd_payload;
      end
    end else if (ctl.rem && ctl.found && flags.ge) begin
      key_next     = right_key;
      payload_next = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    payload <= payload_next;
  end

endmodule

>>> rtl/core/sorted_key_table.sv
// Top level of the sorted key table: a chain of skt_cell instances, the fill
// count, the read selector and the result register. Uses skt_pkg and skt_cell.
//
//   channel   direction  handshake            fields
//   request   in         in_valid / in_stall  op, key_in, payload_in, position
//   result    out        out_valid/out_stall  status, key_out, payload_out,
//                                             entries_used
//
// Each request is handled by all cells together: they compare the key in parallel
// and shift or load at the same edge, and the result is registered into the
// output register at the accepting edge. One request per cycle is sustained unless the result stalls.
// Reset clears the fill count and the result valid; cell contents stay
// undefined until written. A stalled result holds the request side off.
`timescale 1ns / 1ps

module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_PORT_W-1:0] key_in,
  input  logic [PAY_W-1:0]      payload_in,
  input  logic [POS_W-1:0]      position,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [KEY_PORT_W-1:0] key_out,
  output logic [PAY_W-1:0]      payload_out,
  output logic [USED_W-1:0]     entries_used
);

  localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                 accept;
  logic [KEY_W-1:0]     cmd_key;
  logic                 room;
  logic                 found;
  logic                 pos_ok;
  logic [KEY_W-1:0]     read_key;
  logic [PAY_W-1:0]     read_payload;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [31:0]          count_ext;
  logic                 out_valid_next;
  status_t              status_next;
  logic [KEY_PORT_W-1:0] key_out_next;
  logic [PAY_W-1:0]     payload_out_next;

  logic [KEY_W-1:0]     cell_key     [TABLE_DEPTH];
  logic [PAY_W-1:0]     cell_payload [TABLE_DEPTH];
  cell_flag_t           cell_flags   [TABLE_DEPTH];
  cell_ctl_t            cell_ctl     [TABLE_DEPTH];

  // Handshake: a new request enters whenever the result register is free.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cmd_key  = key_in[KEY_W-1:0];
  assign room     = count < CNT_W'(TABLE_DEPTH);
  assign pos_ok   = 32'(position) < 32'(count);

  // Match detection and read selection across all cells.
  always_comb begin
    found        = 1'b0;
    read_key     = '0;
    read_payload = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found = found | cell_flags[i].match;
      if (32'(position) == 32'(i)) begin
        read_key     = cell_key[i];
        read_payload = cell_payload[i];
      end
    end
  end

  // The row of cells, each wired to its neighbors.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] l_key;
    logic [PAY_W-1:0] l_payload;
    logic             l_gt;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;

    if (i == 0) begin : g_first
      assign l_key     = '0;
      assign l_payload = '0;
      assign l_gt      = 1'b0;
    end else begin : g_inner
      assign l_key     = cell_key[i-1];
      assign l_payload = cell_payload[i-1];
      assign l_gt      = cell_flags[i-1].gt;
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_key     = cell_key[i];
      assign r_payload = cell_payload[i];
    end else begin : g_body
      assign r_key     = cell_key[i+1];
      assign r_payload = cell_payload[i+1];
    end

    always_comb begin
      cell_ctl[i].ins      = accept && (op == OP_INSERT) && room;
      cell_ctl[i].rem      = accept && (op == OP_REMOVE);
      cell_ctl[i].found    = found;
      cell_ctl[i].occupied = CNT_W'(i) < count;
      cell_ctl[i].at_tail  = CNT_W'(i) == count;
      cell_ctl[i].left_gt  = l_gt;
    end

    skt_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk          (clk),
      .ctl          (cell_ctl[i]),
      .cmd_key      (cmd_key),
      .cmd_payload  (payload_in),
      .left_key     (l_key),
      .left_payload (l_payload),
      .right_key    (r_key),
      .right_payload(r_payload),
      .flags        (cell_flags[i]),
      .key          (cell_key[i]),
      .payload      (cell_payload[i])
    );
  end

  // Result and fill count for the accepted request.
  always_comb begin
    count_next       = count;
    status_next      = ST_OK;
    key_out_next     = '0;
    payload_out_next = '0;
    case (op)
      OP_INSERT: begin
        if (room) begin
          count_next = count + CNT_W'(1);
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (pos_ok) begin
          key_out_next     = KEY_PORT_W'(read_key);
          payload_out_next = read_payload;
        end else begin
          status_next = ST_BAD_POS;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (!accept) begin
      count_next = count;
    end
    count_ext = 32'(count_next);
  end

  // Result register valid: set on accept, cleared when taken.
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      key_out      <= key_out_next;
      payload_out  <= payload_out_next;
      entries_used <= count_ext[USED_W-1:0];
    end
  end

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  // An insert with room grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_INSERT) && room |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the fill count");

  // A remove of a missing key leaves the count alone and reports not found.
  a_remove_miss: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_REMOVE) && !found
      |=> count == $past(count) && status == ST_NOT_FOUND)
    else $error("failed remove changed the table");

endmodule
